// ===== src/bpa_pkg.sv =====
// Shared types and constants for the next-fit bitmap page allocator.
// Used by bpa_core and the top level; depends on nothing else.
package bpa_pkg;

   localparam int unsigned PAGES_DEF     = 4096;
   localparam int unsigned WORD_BITS_DEF = 64;    // must be a power of two

   localparam int unsigned LIMIT_W  = 13;
   localparam int unsigned START_W  = 12;
   localparam int unsigned LENGTH_W = 13;
   localparam int unsigned TOTAL_W  = 13;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_MRD,
      ST_MWR,
      ST_RESP
   } st_type;

   typedef struct packed {
      logic               ok;
      logic [START_W-1:0] page_granted;
      logic [TOTAL_W-1:0] free_total;
   } result_type;

endpackage

// ===== src/bpa_core.sv =====
// Allocator engine: used-page bitmap memory, scan sequencer and run marking.
// Depends on bpa_pkg.
module bpa_core
   import bpa_pkg::*;
#(
   parameter int unsigned PAGES     = PAGES_DEF,
   parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [LIMIT_W-1:0]  page_limit,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  logic                command,
   input  logic [START_W-1:0]  page_start,
   input  logic [LENGTH_W-1:0] run_length,
   output logic                res_valid,
   input  logic                res_ready,
   output result_type          res
);

   localparam int unsigned MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned WB  = $clog2(WORD_BITS);
   localparam int unsigned CW  = $clog2(PAGES + 1);
   localparam int unsigned IW  = (CW > LENGTH_W + 1) ? CW : LENGTH_W + 1;
   localparam int unsigned XW  = IW + 1;
   localparam logic [IW-1:0] PAGES_I = IW'(PAGES);
   localparam logic [IW-1:0] WORD_I  = IW'(WORD_BITS);
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [WORD_BITS-1:0] ONES = '1;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_ff;

   st_type         st_ff, st_in;
   logic [IW-1:0]  pos_ff, pos_in;
   logic [IW-1:0]  end_ff, end_in;
   logic [XW-1:0]  run_ff, run_in;
   logic           phase_ff, phase_in;
   logic [IW-1:0]  cur_ff, cur_in;
   logic [CW-1:0]  fc_ff, fc_in;
   logic [LENGTH_W-1:0] n_ff, n_in;
   logic           set_ff, set_in;
   logic           ok_ff, ok_in;
   logic [IW-1:0]  gr_ff, gr_in;
   logic [AW-1:0]  clr_ff, clr_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [WORD_BITS-1:0] mem_wd;
   logic [AW-1:0]        mem_ra;

   logic [IW-1:0]        limit;
   logic [IW-1:0]        n_ext;
   logic [IW-1:0]        base, wend, top, span, sh;
   logic [WORD_BITS-1:0] mask;
   logic [XW-1:0]        run_inc, fc_sum;
   logic [IW-1:0]        free_end;

   assign limit   = (IW'(page_limit) < PAGES_I) ? IW'(page_limit) : PAGES_I;
   assign n_ext   = IW'(n_ff);
   assign mem_ra  = AW'(pos_ff >> WB);
   assign run_inc = run_ff + XW'(1);
   assign base    = pos_ff & ~(WORD_I - IW'(1));
   assign wend    = base + WORD_I;
   assign top     = (end_ff < wend) ? end_ff : wend;
   assign span    = top - base;
   assign sh      = WORD_I - span;
   assign mask    = (ONES << pos_ff[WB-1:0]) & (ONES >> sh);
   assign fc_sum  = XW'(fc_ff) + XW'(run_length);
   assign free_end = IW'(page_start) + IW'(run_length);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
         cur_ff <= '0;
         fc_ff  <= '0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         cur_ff <= cur_in;
         fc_ff  <= fc_in;
      end
      pos_ff   <= pos_in;
      end_ff   <= end_in;
      run_ff   <= run_in;
      phase_ff <= phase_in;
      n_ff     <= n_in;
      set_ff   <= set_in;
      ok_ff    <= ok_in;
      gr_ff    <= gr_in;
   end

   // Next state and datapath.
   always_comb begin
      st_in    = st_ff;
      pos_in   = pos_ff;
      end_in   = end_ff;
      run_in   = run_ff;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      fc_in    = fc_ff;
      n_in     = n_ff;
      set_in   = set_ff;
      ok_in    = ok_ff;
      gr_in    = gr_ff;
      clr_in   = clr_ff;
      mem_we   = 1'b0;
      mem_wa   = clr_ff;
      mem_wd   = ONES;
      case (st_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_WORD) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               n_in  = run_length;
               ok_in = 1'b1;
               gr_in = '0;
               if (command == CMD_FREE) begin
                  set_in = 1'b0;
                  pos_in = IW'(page_start);
                  end_in = (free_end < PAGES_I) ? free_end : PAGES_I;
                  fc_in  = (fc_sum > XW'(PAGES)) ? CW'(PAGES) : CW'(fc_sum);
                  st_in  = ST_MRD;
               end else if (run_length == '0) begin
                  ok_in = 1'b0;
                  st_in = ST_RESP;
               end else begin
                  pos_in   = cur_ff;
                  end_in   = limit;
                  phase_in = 1'b0;
                  run_in   = '0;
                  st_in    = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // The word at pos_ff is being read here; bits are taken in ST_STEP.
            if (pos_ff >= end_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  pos_in   = '0;
                  end_in   = (cur_ff < limit) ? cur_ff : limit;
                  run_in   = '0;
               end else begin
                  ok_in = 1'b0;
                  st_in = ST_RESP;
               end
            end else begin
               st_in = ST_STEP;
            end
         end
         ST_STEP: begin
            pos_in = pos_ff + IW'(1);
            if (rd_ff[pos_ff[WB-1:0]]) begin
               run_in = '0;
            end else begin
               run_in = run_inc;
            end
            if (!rd_ff[pos_ff[WB-1:0]] && run_inc == XW'(n_ff)) begin
               gr_in  = pos_ff + IW'(1) - n_ext;
               pos_in = pos_ff + IW'(1) - n_ext;
               end_in = pos_ff + IW'(1);
               cur_in = pos_ff + IW'(1);
               fc_in  = (XW'(fc_ff) > XW'(n_ff)) ? CW'(XW'(fc_ff) - XW'(n_ff)) : '0;
               set_in = 1'b1;
               st_in  = ST_MRD;
            end else if (pos_ff + IW'(1) >= end_ff || pos_ff[WB-1:0] == '1) begin
               st_in = ST_CHECK;
            end
         end
         ST_MRD: begin
            if (pos_ff >= end_ff) begin
               st_in = ST_RESP;
            end else begin
               st_in = ST_MWR;
            end
         end
         ST_MWR: begin
            mem_we = 1'b1;
            mem_wa = mem_ra;
            mem_wd = set_ff ? (rd_ff | mask) : (rd_ff & ~mask);
            pos_in = top;
            st_in  = ST_MRD;
         end
         ST_RESP: begin
            if (res_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      cmd_ready = (st_ff == ST_IDLE);
      res_valid = (st_ff == ST_RESP);
      res.ok           = ok_ff;
      res.page_granted = ok_ff ? gr_ff[START_W-1:0] : '0;
      res.free_total   = TOTAL_W'(fc_ff);
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= CW'(PAGES))
      else $error("free count above page total");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_STEP |-> pos_ff < end_ff)
      else $error("bit step outside scan window");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= PAGES_I)
      else $error("cursor past page total");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.ok |-> res.page_granted == '0)
      else $error("failed allocation reports a page");

endmodule

// ===== src/bitmap_page_allocator_next_fit_top.sv =====
// Top level of the next-fit bitmap page allocator: limit register and response register.
// Depends on bpa_pkg and bpa_core.
// Operation: a free reads and rewrites each word it touches; an allocation scans one bit
// a cycle, with one memory read per word, then marks the run by reading and rewriting
// each word. One request is in flight at a time.
// Reset: synchronous; afterwards a clearing pass over every bitmap word sets every
// page used, during which no beat is taken. page_limit resets to 4096.
module bitmap_page_allocator_next_fit_top
   import bpa_pkg::*;
#(
   parameter int unsigned PAGES     = PAGES_DEF,
   parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [LIMIT_W-1:0]  csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // page_start [11:0], run_length [24:12]
   input  logic                req_tuser,   // command
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // page_granted [11:0], free_total [24:12]
   output logic                rsp_tuser    // ok
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               res_valid, res_ready;
   result_type         res;

   bpa_core #(
      .PAGES     (PAGES),
      .WORD_BITS (WORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .page_limit (limit_ff),
      .cmd_valid  (req_tvalid),
      .cmd_ready  (req_tready),
      .command    (req_tuser),
      .page_start (req_tdata[11:0]),
      .run_length (req_tdata[24:12]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // The response register frees up in the same cycle its beat is taken.
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign limit_in     = csr_we ? csr_wdata : limit_ff;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = (res_valid && res_ready) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = {7'd0, rsp_ff.free_total, rsp_ff.page_granted};

endmodule
